[src/dap_pkg.sv]
// Shared types and constants for the deadline aging process scheduler.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package dap_pkg;

  // Operation codes carried in the kind field of an input beat.
  localparam logic [2:0] KIND_ADMIT   = 3'd0;
  localparam logic [2:0] KIND_TICK    = 3'd1;
  localparam logic [2:0] KIND_PROMOTE = 3'd2;
  localparam logic [2:0] KIND_SELECT  = 3'd3;
  localparam logic [2:0] KIND_UPDATE  = 3'd4;
  localparam logic [2:0] KIND_REMOVE  = 3'd5;

  localparam logic LEVEL_HIGH = 1'b0;
  localparam logic LEVEL_LOW  = 1'b1;

  // One process entry as held in the table memory.
  typedef struct packed {
    logic        level;
    logic        waiting;
    logic [7:0]  pid;
    logic [15:0] deadline;
    logic [31:0] last_run;
    logic [15:0] io_reload;
    logic [15:0] io_left;
  } rec_t;

  // Write controls from the sequencer to the table.
  typedef struct packed {
    logic wr_rec;
    logic set_valid;
    logic clr_valid;
  } wctl_t;

  // Registered results of the arithmetic unit for one entry.
  typedef struct packed {
    logic signed [32:0] prio;
    logic               promote;
    logic [15:0]        io_dec;
    logic               io_zero;
  } unit_res_t;

endpackage

`default_nettype wire

[src/dap_table.sv]
// Process table: entry record memory with a registered read port and
// one write port, plus valid flags in flip-flops. Uses dap_pkg.
`default_nettype none

module dap_table #(
  parameter int MAX_PROCS = 16,
  parameter int IDX_W     = $clog2(MAX_PROCS)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  rd_en,
  input  wire [IDX_W-1:0]      rd_addr,
  output dap_pkg::rec_t        rd_rec,
  output logic                 rd_valid,
  input  wire [IDX_W-1:0]      wr_addr,
  input  dap_pkg::wctl_t       wctl,
  input  dap_pkg::rec_t        wr_rec
);

  dap_pkg::rec_t        entry_mem [MAX_PROCS];
  logic [MAX_PROCS-1:0] valid;

  always_ff @(posedge clk) begin
    if (wctl.wr_rec) begin
      entry_mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_rec <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wctl.set_valid) begin
        valid[wr_addr] <= 1'b1;
      end else if (wctl.clr_valid) begin
        valid[wr_addr] <= 1'b0;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

[src/dap_unit.sv]
// Shared arithmetic unit: elapsed time, select priority, promote test and
// I/O countdown for one entry per cycle, registered. Uses dap_pkg.
`default_nettype none

module dap_unit (
  input  wire                 clk,
  input  wire [31:0]          now,
  input  dap_pkg::rec_t       rec,
  output dap_pkg::unit_res_t  res
);

  logic [31:0] elapsed;
  logic [31:0] twice;
  logic [15:0] dec;

  assign elapsed = now - rec.last_run;
  assign twice   = {15'd0, rec.deadline, 1'b0};
  assign dec     = rec.io_left - 16'd1;

  always_ff @(posedge clk) begin
    // Priority cannot wrap in 33 bits: elapsed is below 2^32 and the
    // deadline below 2^16.
    res.prio    <= $signed({1'b0, elapsed} - {17'd0, rec.deadline});
    res.promote <= (twice < elapsed);
    res.io_dec  <= dec;
    res.io_zero <= (dec == 16'd0);
  end

endmodule

`default_nettype wire

[src/deadline_aging_process_scheduler_top.sv]
// Every command takes one pass over the table, one entry per cycle: a beat
// accepted on start runs until done pulses, and busy stays high from the
// cycle after acceptance through the last table entry, so a new start is
// taken in the done cycle. Each entry goes in turn through the single table
// read port and the shared arithmetic unit. The result (found, chosen_pid,
// refused) is valid only in the one cycle that done is high; the receiver
// cannot stall it. In the table, reset clears only the valid flags, with no
// clearing pass.
// Depends on dap_pkg, dap_table and dap_unit.
`default_nettype none

module deadline_aging_process_scheduler_top #(
  parameter int MAX_PROCS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  kind,
  input  wire  [7:0]  pid,
  input  wire         level,
  input  wire  [15:0] deadline,
  input  wire  [15:0] io_wait,
  input  wire         waiting,
  input  wire  [31:0] now,
  output logic        done,
  output logic        found,
  output logic [7:0]  chosen_pid,
  output logic        refused
);

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);

  // Latched command.
  logic [2:0]  kind_r;
  logic [7:0]  pid_r;
  logic        level_r;
  logic [15:0] deadline_r;
  logic [15:0] io_wait_r;
  logic        waiting_r;
  logic [31:0] now_r;

  // Scan pipeline: issue, table read, unit result.
  logic             iss_act;
  logic [IDX_W-1:0] iss_idx;
  logic             s1_act;
  logic             s1_last;
  logic [IDX_W-1:0] s1_idx;
  logic             s2_act;
  logic             s2_last;
  logic [IDX_W-1:0] s2_idx;
  dap_pkg::rec_t    s2_rec;
  logic             s2_valid;

  dap_pkg::rec_t      rd_rec;
  logic               rd_valid;
  dap_pkg::unit_res_t ures;
  dap_pkg::wctl_t     wctl;
  dap_pkg::rec_t      wr_rec;

  // Running scan results.
  logic               hit;
  logic               hit_next;
  logic               have;
  logic               have_next;
  logic signed [32:0] best_prio;
  logic signed [32:0] best_prio_next;
  logic [7:0]         best_pid;
  logic [7:0]         best_pid_next;

  logic accept;
  logic better;

  assign accept = start && !busy;
  assign busy   = iss_act || s1_act || s2_act;

  dap_table #(
    .MAX_PROCS (MAX_PROCS),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (iss_act),
    .rd_addr  (iss_idx),
    .rd_rec   (rd_rec),
    .rd_valid (rd_valid),
    .wr_addr  (s2_idx),
    .wctl     (wctl),
    .wr_rec   (wr_rec)
  );

  dap_unit u_unit (
    .clk (clk),
    .now (now_r),
    .rec (rd_rec),
    .res (ures)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r     <= kind;
      pid_r      <= pid;
      level_r    <= level;
      deadline_r <= deadline;
      io_wait_r  <= io_wait;
      waiting_r  <= waiting;
      now_r      <= now;
    end
    s1_idx    <= iss_idx;
    s1_last   <= (iss_idx == LAST_IDX);
    s2_idx    <= s1_idx;
    s2_last   <= s1_last;
    s2_rec    <= rd_rec;
    s2_valid  <= rd_valid;
    best_prio <= best_prio_next;
    best_pid  <= best_pid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_act    <= 1'b0;
      iss_idx    <= '0;
      s1_act     <= 1'b0;
      s2_act     <= 1'b0;
      hit        <= 1'b0;
      have       <= 1'b0;
      done       <= 1'b0;
      found      <= 1'b0;
      chosen_pid <= 8'd0;
      refused    <= 1'b0;
    end else begin
      s1_act <= iss_act;
      s2_act <= s1_act;
      if (accept) begin
        iss_act <= 1'b1;
        iss_idx <= '0;
        hit     <= 1'b0;
        have    <= 1'b0;
      end else begin
        if (iss_act) begin
          if (iss_idx == LAST_IDX) begin
            iss_act <= 1'b0;
          end else begin
            iss_idx <= iss_idx + 1'b1;
          end
        end
        hit  <= hit_next;
        have <= have_next;
      end
      done <= s2_act && s2_last;
      if (s2_act && s2_last) begin
        found      <= ((kind_r == dap_pkg::KIND_SELECT) && have_next) ||
                      (((kind_r == dap_pkg::KIND_UPDATE) ||
                        (kind_r == dap_pkg::KIND_REMOVE)) && hit_next);
        chosen_pid <= ((kind_r == dap_pkg::KIND_SELECT) && have_next) ?
                      best_pid_next : 8'd0;
        refused    <= (kind_r == dap_pkg::KIND_ADMIT) && !hit_next;
      end
    end
  end

  assign better = !have || (ures.prio > best_prio) ||
                  ((ures.prio == best_prio) && (s2_rec.pid < best_pid));

  // Decision for the entry at the end of the pipeline. Admit, update and
  // remove act on the first qualifying entry only; hit blocks the rest.
  always_comb begin
    hit_next       = hit;
    have_next      = have;
    best_prio_next = best_prio;
    best_pid_next  = best_pid;
    wctl           = '0;
    wr_rec         = s2_rec;
    if (s2_act) begin
      case (kind_r)
        dap_pkg::KIND_ADMIT: begin
          if (!hit && !s2_valid) begin
            hit_next         = 1'b1;
            wctl.wr_rec      = 1'b1;
            wctl.set_valid   = 1'b1;
            wr_rec.level     = dap_pkg::LEVEL_HIGH;
            wr_rec.waiting   = 1'b0;
            wr_rec.pid       = pid_r;
            wr_rec.deadline  = deadline_r;
            wr_rec.last_run  = now_r;
            wr_rec.io_reload = io_wait_r;
            wr_rec.io_left   = io_wait_r;
          end
        end
        dap_pkg::KIND_TICK: begin
          if (s2_valid && s2_rec.waiting) begin
            wctl.wr_rec = 1'b1;
            if (ures.io_zero) begin
              wr_rec.waiting = 1'b0;
              wr_rec.io_left = s2_rec.io_reload;
            end else begin
              wr_rec.io_left = ures.io_dec;
            end
          end
        end
        dap_pkg::KIND_PROMOTE: begin
          if (s2_valid && (s2_rec.level == dap_pkg::LEVEL_LOW) && ures.promote) begin
            wctl.wr_rec  = 1'b1;
            wr_rec.level = dap_pkg::LEVEL_HIGH;
          end
        end
        dap_pkg::KIND_SELECT: begin
          if (s2_valid && !s2_rec.waiting && (s2_rec.level == level_r) && better) begin
            have_next      = 1'b1;
            best_prio_next = ures.prio;
            best_pid_next  = s2_rec.pid;
          end
        end
        dap_pkg::KIND_UPDATE: begin
          if (!hit && s2_valid && (s2_rec.pid == pid_r)) begin
            hit_next        = 1'b1;
            wctl.wr_rec     = 1'b1;
            wr_rec.waiting  = waiting_r;
            wr_rec.level    = level_r;
            wr_rec.last_run = now_r;
          end
        end
        dap_pkg::KIND_REMOVE: begin
          if (!hit && s2_valid && (s2_rec.pid == pid_r)) begin
            hit_next       = 1'b1;
            wctl.clr_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
